>>> rtl/core/ptcw_pkg.sv
// Shared types, codes and helpers for the paired touch coincidence waiter.
// No dependencies; used by ptcw_step and paired_touch_coincidence_waiter.
`default_nettype none

package ptcw_pkg;

    localparam int POS_W = 8;
    localparam int TIME_W = 32;
    localparam int TOL_W = 16;
    localparam int TMO_W = 24;
    localparam int CFG_W = 24;
    localparam int WS_W = 3;

    localparam logic [POS_W-1:0] NO_POS = 8'd255;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd100;
    localparam logic [TMO_W-1:0] TMO_RESET = 24'd5000;

    // Configuration register indexes
    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_START_SINGLE = 2'd0,
        OP_START_PAIR   = 2'd1,
        OP_TOUCH        = 2'd2,
        OP_TICK         = 2'd3
    } op_t;

    // Wait phase, one-hot
    typedef enum logic [5:0] {
        PH_INACTIVE    = 6'b000001,
        PH_WAIT_FIRST  = 6'b000010,
        PH_WAIT_SECOND = 6'b000100,
        PH_SUCCESS     = 6'b001000,
        PH_FAILURE     = 6'b010000,
        PH_TIMEOUT     = 6'b100000
    } phase_t;

    // Reported wait_state codes
    localparam logic [WS_W-1:0] WS_INACTIVE    = 3'd0;
    localparam logic [WS_W-1:0] WS_WAIT_FIRST  = 3'd1;
    localparam logic [WS_W-1:0] WS_WAIT_SECOND = 3'd2;
    localparam logic [WS_W-1:0] WS_SUCCESS     = 3'd3;
    localparam logic [WS_W-1:0] WS_FAILURE     = 3'd4;
    localparam logic [WS_W-1:0] WS_TIMEOUT     = 3'd5;

    typedef struct packed {
        phase_t             phase;
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  first_touch_time;
        logic [POS_W-1:0]   watch_one;
        logic [POS_W-1:0]   watch_two;
        logic               seen_one;
        logic               seen_two;
        logic               mistake_reported;
    } wait_state_t;

    typedef struct packed {
        logic               accepted;
        logic [WS_W-1:0]    wait_state;
        logic               mistake;
    } result_t;

    // Encode the one-hot phase into the reported code
    function automatic logic [WS_W-1:0] phase_code(input phase_t ph);
        logic [WS_W-1:0] code;
        begin
            unique case (ph)
                PH_INACTIVE:    code = WS_INACTIVE;
                PH_WAIT_FIRST:  code = WS_WAIT_FIRST;
                PH_WAIT_SECOND: code = WS_WAIT_SECOND;
                PH_SUCCESS:     code = WS_SUCCESS;
                PH_FAILURE:     code = WS_FAILURE;
                PH_TIMEOUT:     code = WS_TIMEOUT;
                default:        code = WS_INACTIVE;
            endcase
            return code;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ptcw_step.sv
// Next-state and result logic for one item of the touch coincidence waiter.
// Depends on ptcw_pkg.
`default_nettype none

module ptcw_step (
    input  var ptcw_pkg::wait_state_t           cur,
    input  wire [1:0]                            op,
    input  wire [ptcw_pkg::POS_W-1:0]            pos_a,
    input  wire [ptcw_pkg::POS_W-1:0]            pos_b,
    input  wire [ptcw_pkg::TIME_W-1:0]           time_ms,
    input  wire [ptcw_pkg::TOL_W-1:0]            tolerance_ms,
    input  wire [ptcw_pkg::TMO_W-1:0]            timeout_ms,
    output ptcw_pkg::wait_state_t                nxt,
    output ptcw_pkg::result_t                    res
);

    ptcw_pkg::op_t              op_dec;
    logic                       waiting;
    logic                       single;
    logic                       hit1;
    logic                       hit2;
    logic                       seen1_new;
    logic                       seen2_new;
    logic [ptcw_pkg::TIME_W-1:0] gap;
    logic [ptcw_pkg::TIME_W-1:0] since_start;
    logic                       gap_ok;
    logic                       timed_out;
    logic                       acc;
    logic                       mis;

    assign op_dec = ptcw_pkg::op_t'(op);
    assign waiting = (cur.phase == ptcw_pkg::PH_WAIT_FIRST)
                  || (cur.phase == ptcw_pkg::PH_WAIT_SECOND);
    assign single = (cur.watch_two == ptcw_pkg::NO_POS);
    assign hit1 = (pos_a == cur.watch_one);
    assign hit2 = !single && (pos_a == cur.watch_two);
    assign seen1_new = cur.seen_one | hit1;
    assign seen2_new = cur.seen_two | hit2;

    // Wrapping time differences against the window and the timeout
    assign gap = time_ms - cur.first_touch_time;
    assign since_start = time_ms - cur.start_time;
    assign gap_ok = (gap <= {{(ptcw_pkg::TIME_W-ptcw_pkg::TOL_W){1'b0}}, tolerance_ms});
    assign timed_out = (since_start > {{(ptcw_pkg::TIME_W-ptcw_pkg::TMO_W){1'b0}}, timeout_ms});

    // Advance the wait by one item
    always_comb
    begin
        nxt = cur;
        acc = 1'b0;
        mis = 1'b0;
        unique case (op_dec)
            ptcw_pkg::OP_START_SINGLE, ptcw_pkg::OP_START_PAIR:
            begin
                nxt.phase = ptcw_pkg::PH_WAIT_FIRST;
                nxt.start_time = time_ms;
                nxt.first_touch_time = '0;
                nxt.watch_one = pos_a;
                nxt.watch_two = (op_dec == ptcw_pkg::OP_START_PAIR) ? pos_b : ptcw_pkg::NO_POS;
                nxt.seen_one = 1'b0;
                nxt.seen_two = 1'b0;
                nxt.mistake_reported = 1'b0;
            end
            ptcw_pkg::OP_TOUCH:
            begin
                if (waiting && (hit1 || hit2))
                begin
                    if (single)
                    begin
                        // single mode: only the first touch counts
                        if (cur.phase == ptcw_pkg::PH_WAIT_FIRST)
                        begin
                            nxt.seen_one = 1'b1;
                            nxt.phase = ptcw_pkg::PH_SUCCESS;
                            acc = 1'b1;
                        end
                    end
                    else
                    begin
                        acc = 1'b1;
                        nxt.seen_one = seen1_new;
                        nxt.seen_two = seen2_new;
                        if (cur.phase == ptcw_pkg::PH_WAIT_FIRST)
                        begin
                            nxt.first_touch_time = time_ms;
                            nxt.phase = ptcw_pkg::PH_WAIT_SECOND;
                        end
                        else if (seen1_new && seen2_new)
                        begin
                            nxt.phase = gap_ok ? ptcw_pkg::PH_SUCCESS : ptcw_pkg::PH_FAILURE;
                        end
                    end
                end
            end
            ptcw_pkg::OP_TICK:
            begin
                if ((cur.phase == ptcw_pkg::PH_WAIT_SECOND) && !single)
                begin
                    // window expired: fail and pulse mistake once
                    if (!gap_ok)
                    begin
                        nxt.phase = ptcw_pkg::PH_FAILURE;
                        if (!cur.mistake_reported)
                        begin
                            nxt.mistake_reported = 1'b1;
                            mis = 1'b1;
                        end
                    end
                end
                else if (cur.phase == ptcw_pkg::PH_WAIT_FIRST)
                begin
                    if (timed_out)
                    begin
                        nxt.phase = ptcw_pkg::PH_TIMEOUT;
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    assign res.accepted = acc;
    assign res.wait_state = ptcw_pkg::phase_code(nxt.phase);
    assign res.mistake = mis;

endmodule

`default_nettype wire

>>> rtl/core/paired_touch_coincidence_waiter.sv
// An accepted item's result appears on the output register in the next cycle.
// Throughput: one item per cycle unless stalled; the step is a single compare-and-update pass.
// An item is taken while the output register is empty or being drained.
// Reset (rst_n low, asynchronous): phase inactive, watch positions 255,
// times and flags zero, tolerance 100 ms, timeout 5000 ms, output empty.
// Top level; depends on ptcw_pkg and ptcw_step.
`default_nettype none

module paired_touch_coincidence_waiter (
    input  wire                              clk,
    input  wire                              rst_n,
    // configuration write port
    input  wire                              cfg_we,
    input  wire                              cfg_index,
    input  wire [ptcw_pkg::CFG_W-1:0]        cfg_data,
    // item input
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire [1:0]                        op,
    input  wire [ptcw_pkg::POS_W-1:0]        pos_a,
    input  wire [ptcw_pkg::POS_W-1:0]        pos_b,
    input  wire [ptcw_pkg::TIME_W-1:0]       time_ms,
    // result output
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic                             accepted,
    output logic [ptcw_pkg::WS_W-1:0]        wait_state,
    output logic                             mistake
);

    logic [ptcw_pkg::TOL_W-1:0]  tolerance_reg;
    logic [ptcw_pkg::TMO_W-1:0]  timeout_reg;
    ptcw_pkg::wait_state_t       state_reg;
    ptcw_pkg::wait_state_t       state_next;
    ptcw_pkg::result_t           res_next;
    ptcw_pkg::result_t           res_reg;
    logic                        out_valid_reg;
    logic                        in_fire;

    // Take a new item unless a finished result is held back
    assign in_stall = out_valid_reg && out_stall;
    assign in_fire = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= ptcw_pkg::TOL_RESET;
            timeout_reg <= ptcw_pkg::TMO_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ptcw_pkg::CFG_TOLERANCE)
            begin
                tolerance_reg <= cfg_data[ptcw_pkg::TOL_W-1:0];
            end
            else
            begin
                timeout_reg <= cfg_data[ptcw_pkg::TMO_W-1:0];
            end
        end
    end

    ptcw_step u_step (
        .cur          (state_reg),
        .op           (op),
        .pos_a        (pos_a),
        .pos_b        (pos_b),
        .time_ms      (time_ms),
        .tolerance_ms (tolerance_reg),
        .timeout_ms   (timeout_reg),
        .nxt          (state_next),
        .res          (res_next)
    );

    // Wait state: advance on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase <= ptcw_pkg::PH_INACTIVE;
            state_reg.start_time <= '0;
            state_reg.first_touch_time <= '0;
            state_reg.watch_one <= ptcw_pkg::NO_POS;
            state_reg.watch_two <= ptcw_pkg::NO_POS;
            state_reg.seen_one <= 1'b0;
            state_reg.seen_two <= 1'b0;
            state_reg.mistake_reported <= 1'b0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Output valid: set on a new item, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: load with the item's result
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted = res_reg.accepted;
    assign wait_state = res_reg.wait_state;
    assign mistake = res_reg.mistake;

    // A start always leaves the block waiting for the first touch
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (op == ptcw_pkg::OP_START_SINGLE || op == ptcw_pkg::OP_START_PAIR)
        |=> out_valid && (wait_state == ptcw_pkg::WS_WAIT_FIRST))
    else $error("start item did not arm the wait");

    // Only a touch can be accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (op != ptcw_pkg::OP_TOUCH) |=> !accepted)
    else $error("accepted raised for a non-touch item");

    // A mistake pulse comes only with a failed pair
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mistake |-> (wait_state == ptcw_pkg::WS_FAILURE) && !accepted)
    else $error("mistake without failure");

    // Waiting for the second touch implies pair mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == ptcw_pkg::PH_WAIT_SECOND)
        |-> (state_reg.watch_two != ptcw_pkg::NO_POS))
    else $error("second-touch wait in single mode");

    // An item is never taken while a result is held back
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> $stable(res_reg))
    else $error("held result overwritten");

endmodule

`default_nettype wire
